// ===== hdl/command_line_matcher_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Command line matcher assertion macros
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef COMMAND_LINE_MATCHER_UNIT_MACROS_SVH
`define COMMAND_LINE_MATCHER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("command line matcher check failed");

// The consequent must hold in the cycle after the antecedent.
`define CLM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("command line matcher check failed");

`endif

// ===== hdl/clm_pkg.sv =====
// ---------------------------------------------------------------------------
// Command line matcher package
// Command words, event codes, character codes and number parse phases.
// ---------------------------------------------------------------------------
`default_nettype none

package clm_pkg;

    localparam int unsigned LINE_BUFFER_SIZE_DEF = 128;
    localparam int unsigned NUM_WORDS            = 10;
    localparam int unsigned WORD_MAX_LEN         = 24;
    localparam int unsigned WORD_BITS            = WORD_MAX_LEN * 8;
    localparam int unsigned FREQ_WORD            = 2;
    localparam logic [31:0] FREQ_RESET           = 32'd10_000_000;

    typedef enum logic [3:0] {
        CMD_RESET    = 4'd0,
        CMD_APP      = 4'd1,
        CMD_FREQ     = 4'd2,
        CMD_RISE     = 4'd3,
        CMD_FALL     = 4'd4,
        CMD_RUN      = 4'd5,
        CMD_READY    = 4'd6,
        CMD_RECEIVED = 4'd7,
        CMD_CONTINUE = 4'd8,
        CMD_STOP     = 4'd9,
        CMD_UNKNOWN  = 4'd10
    } t_event_code;

    typedef enum logic [2:0] {
        PH_TOKEN  = 3'd0,
        PH_BLANKS = 3'd1,
        PH_SIGN   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_DONE   = 3'd4,
        PH_OVER   = 3'd5
    } t_num_phase;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [WORD_BITS-1:0] WORD_TEXT [NUM_WORDS] = '{
        WORD_BITS'("RESET"),
        WORD_BITS'("APP"),
        WORD_BITS'({"CONFIGURE_", "FREQ"}),
        WORD_BITS'({"CONFIGURE_", "TRIG_RISE_EDGE"}),
        WORD_BITS'({"CONFIGURE_", "TRIG_FALL_EDGE"}),
        WORD_BITS'({"RUN_", "START"}),
        WORD_BITS'({"READY_", "FOR_DATA"}),
        WORD_BITS'("RECEIVED"),
        WORD_BITS'("CONTINUE"),
        WORD_BITS'("STOP")
    };

    localparam int unsigned WORD_LEN [NUM_WORDS] = '{5, 3, 14, 24, 24, 9, 14, 8, 8, 4};

    // Strings are right-justified, so the first character sits in the top used byte.
    function automatic logic [7:0] word_char(input int unsigned idx, input logic [4:0] pos);
        int unsigned sh;
        logic [7:0]  ch;
        ch = 8'h00;
        if (32'(pos) < WORD_LEN[idx]) begin
            sh = 8 * (WORD_LEN[idx] - 1 - 32'(pos));
            ch = 8'(WORD_TEXT[idx] >> sh);
        end
        return ch;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/command_line_matcher_unit.sv =====
// A result is registered once its terminating byte leaves the input register.
// Throughput: one byte per cycle; the match and digit update for a byte is one
// register-to-register step between the input register and the result register.
// A stalled result blocks the input only once the input register is also full.
// Synchronous active-low reset empties the line and sets the frequency to 10000000.
// ---------------------------------------------------------------------------
// Command line matcher unit
// Assembles received bytes into lines, decodes the command word and parses
// the sampling frequency argument.
// ---------------------------------------------------------------------------
`default_nettype none

`include "command_line_matcher_unit_macros.svh"

module command_line_matcher_unit #(
    parameter int unsigned LINE_BUFFER_SIZE = clm_pkg::LINE_BUFFER_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_ev_valid,
    input  wire logic        i_ev_ready,
    output logic [3:0]       o_event_code,
    output logic [31:0]      o_frequency,
    output logic             o_frequency_updated
);

    localparam int unsigned POS_W   = $clog2(LINE_BUFFER_SIZE);
    localparam int unsigned N_WORDS = clm_pkg::NUM_WORDS;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_BUFFER_SIZE - 1);
    localparam logic [N_WORDS-1:0] ALL_ALIVE = '1;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;

    logic [POS_W-1:0]      r_line_pos,   n_line_pos;
    logic [N_WORDS-1:0]    r_alive,      n_alive;
    logic                  r_nul_seen,   n_nul_seen;
    clm_pkg::t_num_phase   r_phase,      n_phase;
    logic                  r_neg,        n_neg;
    logic                  r_digit_seen, n_digit_seen;
    logic [31:0]           r_acc,        n_acc;
    logic [31:0]           r_freq,       n_freq;

    logic                  r_out_valid;
    clm_pkg::t_event_code  r_out_code,   n_out_code;
    logic                  r_out_upd,    n_out_upd;

    logic                  advance;
    logic                  is_term;
    logic                  emit;
    logic                  line_full;
    logic                  run_text;
    logic [N_WORDS-1:0]    close_mask;
    logic [N_WORDS-1:0]    char_mask;
    logic [N_WORDS-1:0]    final_alive;
    clm_pkg::t_event_code  found_code;
    clm_pkg::t_num_phase   step_phase;
    logic                  step_neg;
    logic                  step_digit_seen;
    logic [31:0]           step_acc;
    logic [35:0]           acc_x10;

    assign advance    = r_in_valid && (!r_out_valid || i_ev_ready);
    assign o_rx_ready = !r_in_valid || advance;

    assign is_term   = (r_in_byte == clm_pkg::CH_LF) || (r_in_byte == clm_pkg::CH_CR);
    assign emit      = advance && is_term && (r_line_pos != '0);
    assign line_full = (r_line_pos >= POS_LAST);
    assign run_text  = !r_nul_seen && (r_in_byte != clm_pkg::CH_NUL);

    always_comb begin
        for (int i = 0; i < N_WORDS; i++) begin
            if (i == clm_pkg::FREQ_WORD) begin
                close_mask[i] = (32'(r_line_pos) >= clm_pkg::WORD_LEN[i]);
            end else begin
                close_mask[i] = (32'(r_line_pos) == clm_pkg::WORD_LEN[i]);
            end
            if (32'(r_line_pos) < clm_pkg::WORD_LEN[i]) begin
                char_mask[i] = (clm_pkg::word_char(i, r_line_pos[4:0]) == r_in_byte);
            end else begin
                char_mask[i] = (i == clm_pkg::FREQ_WORD);
            end
        end
    end

    always_comb begin
        final_alive = r_nul_seen ? r_alive : (r_alive & close_mask);
        found_code  = clm_pkg::CMD_UNKNOWN;
        for (int i = N_WORDS - 1; i >= 0; i--) begin
            if (final_alive[i]) begin
                found_code = clm_pkg::t_event_code'(4'(i));
            end
        end
    end

    // Number parse phase, next state for one text character.
    always_comb begin
        step_phase = r_phase;
        case (r_phase)
            clm_pkg::PH_TOKEN: begin
                if (clm_pkg::is_blank(r_in_byte)) begin
                    step_phase = clm_pkg::PH_BLANKS;
                end
            end
            clm_pkg::PH_BLANKS: begin
                if (clm_pkg::is_blank(r_in_byte)) begin
                    step_phase = clm_pkg::PH_BLANKS;
                end else if (r_in_byte inside {clm_pkg::CH_PLUS, clm_pkg::CH_MINUS}) begin
                    step_phase = clm_pkg::PH_SIGN;
                end else if (clm_pkg::is_digit(r_in_byte)) begin
                    step_phase = clm_pkg::PH_DIGITS;
                end else begin
                    step_phase = clm_pkg::PH_DONE;
                end
            end
            clm_pkg::PH_SIGN: begin
                step_phase = clm_pkg::is_digit(r_in_byte) ? clm_pkg::PH_DIGITS
                                                          : clm_pkg::PH_DONE;
            end
            clm_pkg::PH_DIGITS: begin
                if (!clm_pkg::is_digit(r_in_byte)) begin
                    step_phase = clm_pkg::PH_DONE;
                end else if (acc_x10[35:32] != '0) begin
                    step_phase = clm_pkg::PH_OVER;
                end
            end
            default: begin
                step_phase = r_phase;
            end
        endcase
    end

    assign acc_x10 = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {32'd0, r_in_byte[3:0]};

    // Number parse datapath for one text character.
    always_comb begin
        step_neg        = r_neg;
        step_digit_seen = r_digit_seen;
        step_acc        = r_acc;
        case (r_phase)
            clm_pkg::PH_BLANKS, clm_pkg::PH_SIGN: begin
                if (r_phase == clm_pkg::PH_BLANKS &&
                    (r_in_byte == clm_pkg::CH_PLUS || r_in_byte == clm_pkg::CH_MINUS)) begin
                    step_neg = (r_in_byte == clm_pkg::CH_MINUS);
                end else if (clm_pkg::is_digit(r_in_byte)) begin
                    step_acc        = {28'd0, r_in_byte[3:0]};
                    step_digit_seen = 1'b1;
                end
            end
            clm_pkg::PH_DIGITS: begin
                if (clm_pkg::is_digit(r_in_byte)) begin
                    step_acc = (acc_x10[35:32] != '0) ? '1 : acc_x10[31:0];
                end
            end
            default: begin
                step_acc = r_acc;
            end
        endcase
    end

    always_comb begin
        n_line_pos   = r_line_pos;
        n_alive      = r_alive;
        n_nul_seen   = r_nul_seen;
        n_phase      = r_phase;
        n_neg        = r_neg;
        n_digit_seen = r_digit_seen;
        n_acc        = r_acc;
        n_freq       = r_freq;
        n_out_code   = found_code;
        n_out_upd    = 1'b0;
        if (advance) begin
            if (is_term || line_full) begin
                if (emit && found_code == clm_pkg::CMD_FREQ && r_digit_seen) begin
                    n_freq    = (r_phase != clm_pkg::PH_OVER && r_neg) ? (32'd0 - r_acc)
                                                                       : r_acc;
                    n_out_upd = 1'b1;
                end
                if (!is_term || r_line_pos != '0) begin
                    n_line_pos   = '0;
                    n_alive      = ALL_ALIVE;
                    n_nul_seen   = 1'b0;
                    n_phase      = clm_pkg::PH_TOKEN;
                    n_neg        = 1'b0;
                    n_digit_seen = 1'b0;
                    n_acc        = '0;
                end
            end else begin
                n_line_pos = r_line_pos + 1'b1;
                if (!r_nul_seen && r_in_byte == clm_pkg::CH_NUL) begin
                    n_alive    = r_alive & close_mask;
                    n_nul_seen = 1'b1;
                end else if (run_text) begin
                    n_alive      = r_alive & char_mask;
                    n_phase      = step_phase;
                    n_neg        = step_neg;
                    n_digit_seen = step_digit_seen;
                    n_acc        = step_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_line_pos   <= '0;
            r_alive      <= ALL_ALIVE;
            r_nul_seen   <= 1'b0;
            r_phase      <= clm_pkg::PH_TOKEN;
            r_neg        <= 1'b0;
            r_digit_seen <= 1'b0;
            r_acc        <= '0;
            r_freq       <= clm_pkg::FREQ_RESET;
        end else begin
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ev_ready) begin
                r_out_valid <= 1'b0;
            end
            r_line_pos   <= n_line_pos;
            r_alive      <= n_alive;
            r_nul_seen   <= n_nul_seen;
            r_phase      <= n_phase;
            r_neg        <= n_neg;
            r_digit_seen <= n_digit_seen;
            r_acc        <= n_acc;
            r_freq       <= n_freq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (emit) begin
            r_out_code <= n_out_code;
            r_out_upd  <= n_out_upd;
        end
    end

    assign o_ev_valid          = r_out_valid;
    assign o_event_code        = r_out_code;
    assign o_frequency         = r_freq;
    assign o_frequency_updated = r_out_upd;

    `CLM_ASSERT_SAME(a_upd_only_freq, o_ev_valid && r_out_upd, o_event_code == clm_pkg::CMD_FREQ)
    `CLM_ASSERT_SAME(a_pos_in_range, 1'b1, r_line_pos <= POS_LAST)
    `CLM_ASSERT_SAME(a_nul_needs_text, r_nul_seen, r_line_pos != '0)
    `CLM_ASSERT_NEXT(a_term_gives_result, emit, o_ev_valid && r_line_pos == '0)

endmodule

`default_nettype wire

// ===== verif/command_line_matcher_unit_tb.sv =====
// ---------------------------------------------------------------------------
// Command line matcher unit testbench
// Sends command lines byte by byte: first a table of directed lines, then random
// well-formed and broken lines. Typed rows carry their expected event, and a
// byte-level predictor builds it otherwise; block events are checked in order.
// ---------------------------------------------------------------------------
module command_line_matcher_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BYTES_PER_PHASE = 400;
    localparam int MAX_REPORTS = 10;
    localparam string W_CFG = "CONFIGURE_";
    localparam string W_RUN = "RUN_";
    localparam string W_READY = "READY_";

    typedef struct {
        clm_pkg::t_event_code code;
        logic [31:0]          freq;
        logic                 upd;
    } t_cmd_event;

    typedef struct {
        string                text;
        int                   nul_at;
        int                   fill_n;
        logic [7:0]           fill_b;
        logic [7:0]           term;
        bit                   typed;
        clm_pkg::t_event_code code;
        logic [31:0]          freq;
        logic                 upd;
    } t_line_case;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_ev_valid;
    logic        i_ev_ready = 1'b0;
    logic [3:0]  o_event_code;
    logic [31:0] o_frequency;
    logic        o_frequency_updated;

    string cmd_text [clm_pkg::NUM_WORDS] = '{
        "RESET", "APP", {W_CFG, "FREQ"}, {W_CFG, "TRIG_RISE_EDGE"},
        {W_CFG, "TRIG_FALL_EDGE"}, {W_RUN, "START"}, {W_READY, "FOR_DATA"},
        "RECEIVED", "CONTINUE", "STOP"
    };
    logic [7:0] blank_chars [4] = '{clm_pkg::CH_SPACE, clm_pkg::CH_TAB,
                                    clm_pkg::CH_VT, clm_pkg::CH_FF};

    t_line_case directed_lines [26] = '{
        '{"RESET", -1, 0, 8'h00, clm_pkg::CH_CR,
          1'b1, clm_pkg::CMD_RESET, clm_pkg::FREQ_RESET, 1'b0},
        '{"APP", -1, 0, 8'h00, clm_pkg::CH_LF,
          1'b1, clm_pkg::CMD_APP, clm_pkg::FREQ_RESET, 1'b0},
        '{"", -1, 0, 8'h00, clm_pkg::CH_CR,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{{W_CFG, "FREQ 4294967295"}, -1, 0, 8'h00, clm_pkg::CH_CR,
          1'b1, clm_pkg::CMD_FREQ, 32'hFFFF_FFFF, 1'b1},
        '{{W_CFG, "FREQ 4294967296"}, -1, 0, 8'h00, clm_pkg::CH_LF,
          1'b1, clm_pkg::CMD_FREQ, 32'hFFFF_FFFF, 1'b1},
        '{{W_CFG, "FREQ -4294967296"}, -1, 0, 8'h00, clm_pkg::CH_CR,
          1'b1, clm_pkg::CMD_FREQ, 32'hFFFF_FFFF, 1'b1},
        '{{W_CFG, "FREQ -1"}, -1, 0, 8'h00, clm_pkg::CH_LF,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{{W_CFG, "FREQ\t\v\f +0"}, -1, 0, 8'h00, clm_pkg::CH_CR,
          1'b1, clm_pkg::CMD_FREQ, 32'd0, 1'b1},
        '{{W_CFG, "FREQ"}, -1, 0, 8'h00, clm_pkg::CH_LF,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{{W_CFG, "FREQXYZ 1234"}, -1, 0, 8'h00, clm_pkg::CH_CR,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{{W_CFG, "FREQ -"}, -1, 0, 8'h00, clm_pkg::CH_LF,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{{W_CFG, "FREQ 12ab 34"}, -1, 0, 8'h00, clm_pkg::CH_CR,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{{W_CFG, "TRIG_RISE_EDGE"}, -1, 0, 8'h00, clm_pkg::CH_LF,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{{W_CFG, "TRIG_FALL_EDGE"}, -1, 0, 8'h00, clm_pkg::CH_CR,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{{W_RUN, "START"}, -1, 0, 8'h00, clm_pkg::CH_LF,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{{W_READY, "FOR_DATA"}, -1, 0, 8'h00, clm_pkg::CH_CR,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{"RECEIVED", -1, 0, 8'h00, clm_pkg::CH_LF,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{"CONTINUE", -1, 0, 8'h00, clm_pkg::CH_CR,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{"STOP", -1, 0, 8'h00, clm_pkg::CH_LF,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{"STOPS", -1, 0, 8'h00, clm_pkg::CH_CR,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{"STOP#junk", 4, 0, 8'h00, clm_pkg::CH_LF,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{{W_CFG, "FREQ 77#99"}, 17, 0, 8'h00, clm_pkg::CH_CR,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{"#", 0, 0, 8'h00, clm_pkg::CH_LF,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{"", -1, 127, 8'hFF, clm_pkg::CH_CR,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{"XRESET", -1, 127, 8'h80, clm_pkg::CH_LF,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0},
        '{"", -1, 128, 8'h7F, clm_pkg::CH_CR,
          1'b0, clm_pkg::CMD_UNKNOWN, 32'd0, 1'b0}
    };

    int                  line_len;
    logic [9:0]          word_live;
    logic                nul_hit;
    clm_pkg::t_num_phase num_phase;
    logic                num_neg;
    logic                num_digit;
    logic [31:0]         num_acc;
    logic [31:0]         freq_reg = clm_pkg::FREQ_RESET;

    t_cmd_event  pending_events [$];
    logic [7:0]  line_bytes [$];
    bit          typed_on = 1'b0;
    t_cmd_event  typed_entry;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          error_count = 0;
    int          idle_cycles = 0;

    command_line_matcher_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_rx_valid          (i_rx_valid),
        .o_rx_ready          (o_rx_ready),
        .i_rx_byte           (i_rx_byte),
        .o_ev_valid          (o_ev_valid),
        .i_ev_ready          (i_ev_ready),
        .o_event_code        (o_event_code),
        .o_frequency         (o_frequency),
        .o_frequency_updated (o_frequency_updated)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_line();
        line_len = 0;
        word_live = '1;
        nul_hit = 1'b0;
        num_phase = clm_pkg::PH_TOKEN;
        num_neg = 1'b0;
        num_digit = 1'b0;
        num_acc = 32'd0;
    endfunction

    function automatic void trim_words(input int len);
        for (int i = 0; i < clm_pkg::NUM_WORDS; i++) begin
            if (i == clm_pkg::FREQ_WORD ? len < cmd_text[i].len()
                                        : len != cmd_text[i].len()) begin
                word_live[i] = 1'b0;
            end
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] c);
        clm_pkg::t_event_code code;
        logic [31:0] v;
        logic        upd;
        logic        blank;
        logic        digit;
        logic [63:0] wide;
        blank = (c == clm_pkg::CH_SPACE || c == clm_pkg::CH_TAB
                 || c == clm_pkg::CH_VT || c == clm_pkg::CH_FF);
        digit = (c >= clm_pkg::CH_ZERO && c <= clm_pkg::CH_NINE);
        if (c == clm_pkg::CH_CR || c == clm_pkg::CH_LF) begin
            if (line_len != 0) begin
                if (!nul_hit) begin
                    trim_words(line_len);
                end
                code = clm_pkg::CMD_UNKNOWN;
                for (int i = clm_pkg::NUM_WORDS - 1; i >= 0; i--) begin
                    if (word_live[i]) begin
                        code = clm_pkg::t_event_code'(4'(i));
                    end
                end
                upd = 1'b0;
                if (code == clm_pkg::CMD_FREQ && num_digit) begin
                    v = num_acc;
                    if (num_phase != clm_pkg::PH_OVER && num_neg) begin
                        v = 32'd0 - num_acc;
                    end
                    freq_reg = v;
                    upd = 1'b1;
                end
                if (typed_on) begin
                    pending_events.push_back(typed_entry);
                end else begin
                    pending_events.push_back(t_cmd_event'{code, freq_reg, upd});
                end
                clear_line();
            end
        end else if (line_len >= clm_pkg::LINE_BUFFER_SIZE_DEF - 1) begin
            clear_line();
        end else begin
            if (!nul_hit && c == clm_pkg::CH_NUL) begin
                trim_words(line_len);
                nul_hit = 1'b1;
            end else if (!nul_hit) begin
                for (int i = 0; i < clm_pkg::NUM_WORDS; i++) begin
                    if (word_live[i]) begin
                        if (line_len < cmd_text[i].len()) begin
                            if (cmd_text[i][line_len] != c) begin
                                word_live[i] = 1'b0;
                            end
                        end else if (i != clm_pkg::FREQ_WORD) begin
                            word_live[i] = 1'b0;
                        end
                    end
                end
                case (num_phase)
                    clm_pkg::PH_TOKEN: begin
                        if (blank) begin
                            num_phase = clm_pkg::PH_BLANKS;
                        end
                    end
                    clm_pkg::PH_BLANKS, clm_pkg::PH_SIGN: begin
                        if (num_phase == clm_pkg::PH_BLANKS && blank) begin
                            num_phase = clm_pkg::PH_BLANKS;
                        end else if (num_phase == clm_pkg::PH_BLANKS
                                     && (c == clm_pkg::CH_PLUS || c == clm_pkg::CH_MINUS)) begin
                            num_neg = (c == clm_pkg::CH_MINUS);
                            num_phase = clm_pkg::PH_SIGN;
                        end else if (digit) begin
                            num_acc = 32'(c) - 32'(clm_pkg::CH_ZERO);
                            num_digit = 1'b1;
                            num_phase = clm_pkg::PH_DIGITS;
                        end else begin
                            num_phase = clm_pkg::PH_DONE;
                        end
                    end
                    clm_pkg::PH_DIGITS: begin
                        if (digit) begin
                            wide = 64'(num_acc) * 64'd10 + 64'(c) - 64'(clm_pkg::CH_ZERO);
                            if (wide > 64'hFFFF_FFFF) begin
                                num_acc = 32'hFFFF_FFFF;
                                num_phase = clm_pkg::PH_OVER;
                            end else begin
                                num_acc = wide[31:0];
                            end
                        end else begin
                            num_phase = clm_pkg::PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            line_len++;
        end
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    function automatic logic [7:0] any_text_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (b == clm_pkg::CH_CR || b == clm_pkg::CH_LF);
        return b;
    endfunction

    function automatic void add_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            line_bytes.push_back(s[k]);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < src_idle_pct) begin
            i_rx_valid <= 1'b0;
            do begin
                @(negedge i_clk);
            end while ($urandom_range(99) < src_idle_pct);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_rx_ready) begin
            @(posedge i_clk);
        end
        decode_byte(b);
        @(negedge i_clk);
    endtask

    task automatic make_line();
        int    kind;
        int    w;
        int    n;
        int    r;
        string s;
        line_bytes.delete();
        kind = $urandom_range(99);
        w = $urandom_range(clm_pkg::NUM_WORDS - 1);
        if (kind < 25 && w != clm_pkg::FREQ_WORD) begin
            add_text(cmd_text[w]);
        end else if (kind < 55) begin
            add_text(cmd_text[clm_pkg::FREQ_WORD]);
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 3)) line_bytes.push_back(8'($urandom_range(65, 90)));
            end
            n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
            repeat (n) line_bytes.push_back(blank_chars[$urandom_range(3)]);
            r = $urandom_range(9);
            if (r < 2) begin
                line_bytes.push_back(clm_pkg::CH_MINUS);
            end else if (r == 2) begin
                line_bytes.push_back(clm_pkg::CH_PLUS);
            end
            r = $urandom_range(9);
            if (r < 4) begin
                add_text($sformatf("%0d", $urandom()));
            end else if (r < 6) begin
                repeat ($urandom_range(10, 14)) line_bytes.push_back(8'($urandom_range(48, 57)));
            end else if (r < 9) begin
                repeat ($urandom_range(1, 9)) line_bytes.push_back(8'($urandom_range(48, 57)));
            end
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(1, 4)) line_bytes.push_back(any_text_byte());
            end
        end else if (kind < 70) begin
            s = cmd_text[w];
            add_text(s);
            n = $urandom_range(s.len() - 1);
            case ($urandom_range(3))
                0: line_bytes[n] = any_text_byte();
                1: void'(line_bytes.pop_back());
                2: line_bytes.push_back(any_text_byte());
                default: line_bytes[n] = line_bytes[n] ^ 8'h20;
            endcase
        end else if (kind < 80) begin
            if ($urandom_range(3) != 0) begin
                add_text(cmd_text[w]);
            end
            line_bytes.push_back(clm_pkg::CH_NUL);
            repeat ($urandom_range(5)) line_bytes.push_back(any_text_byte());
        end else if (kind < 90) begin
            repeat ($urandom_range(30)) line_bytes.push_back(8'($urandom_range(255)));
        end else if (kind < 95) begin
            repeat ($urandom_range(120, 135)) line_bytes.push_back(any_text_byte());
            if ($urandom_range(1) == 0) begin
                add_text(cmd_text[w]);
            end
        end
        line_bytes.push_back($urandom_range(1) ? clm_pkg::CH_CR : clm_pkg::CH_LF);
    endtask

    always @(negedge i_clk) begin
        i_ev_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        t_cmd_event want;
        if (i_rst_n && o_ev_valid && i_ev_ready) begin
            if (pending_events.size() == 0) begin
                note_error($sformatf("Unexpected event: code %0d freq %0d upd %0b",
                                     o_event_code, o_frequency, o_frequency_updated));
            end else begin
                want = pending_events.pop_front();
                if (o_event_code !== want.code || o_frequency !== want.freq
                    || o_frequency_updated !== want.upd) begin
                    note_error($sformatf(
                        "Event mismatch: expected code %0d freq %0d upd %0b, got %0d %0d %0b",
                        want.code, want.freq, want.upd,
                        o_event_code, o_frequency, o_frequency_updated));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_rx_valid && o_rx_ready) || (o_ev_valid && i_ev_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int src_pct [3];
        int snk_pct [3];
        int random_bytes;
        t_line_case row;
        src_pct = '{15, 87, 0};
        snk_pct = '{87, 15, 0};
        random_bytes = 0;
        clear_line();
        src_idle_pct = src_pct[0];
        snk_idle_pct = snk_pct[0];
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_lines[r]) begin
            row = directed_lines[r];
            line_bytes.delete();
            repeat (row.fill_n) line_bytes.push_back(row.fill_b);
            for (int k = 0; k < row.text.len(); k++) begin
                line_bytes.push_back(k == row.nul_at ? clm_pkg::CH_NUL : row.text[k]);
            end
            line_bytes.push_back(row.term);
            typed_on = row.typed;
            typed_entry = '{row.code, row.freq, row.upd};
            foreach (line_bytes[k]) begin
                send_byte(line_bytes[k]);
            end
            typed_on = 1'b0;
        end

        for (int p = 0; p < 3; p++) begin
            src_idle_pct = src_pct[p];
            snk_idle_pct = snk_pct[p];
            while (random_bytes < RANDOM_BYTES_PER_PHASE * (p + 1)) begin
                make_line();
                foreach (line_bytes[k]) begin
                    send_byte(line_bytes[k]);
                end
                random_bytes += line_bytes.size();
            end
        end

        i_rx_valid <= 1'b0;
        while (pending_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (pending_events.size() != 0) begin
            note_error($sformatf("%0d events never arrived", pending_events.size()));
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
